// ----- sv/world_to_screen_projection_top_assert.svh -----
// ----------------------------------------------------------------------------
// world_to_screen_projection_top assertion macros
// shared property forms for the projection unit checks
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_TOP_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_TOP_ASSERT_SVH

// same-cycle implication
`define WSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsp assertion failed");

// next-cycle implication
`define WSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsp assertion failed");

`endif

// ----- sv/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wsp_pkg
// types, constants and helpers of the vertex projection unit
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int DIM_W     = 14;
  localparam int PIX_W     = 30;
  localparam int MAT_AW    = 5;
  localparam int PROD_W    = 2 * WORD_W - FRAC_BITS;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DIV_W     = WORD_W + FRAC_BITS;
  localparam int OFF_W     = FRAC_BITS + 2;
  localparam int PM_W      = OFF_W + DIM_W;
  localparam int PXE_W     = (PM_W > 32) ? PM_W : 32;
  localparam int FAR_W     = WORD_W + 10;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd1920;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd1080;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [31:0][WORD_W-1:0] mstore_t;

  localparam word_t FX_ONE   = word_t'(64'sd1 <<< FRAC_BITS);
  localparam word_t WORD_MAX = 32'sh7FFFFFFF;
  localparam word_t WORD_MIN = 32'sh80000000;
  localparam logic signed [FAR_W-1:0] FAR_LIM = FAR_W'(64'sd999 <<< FRAC_BITS);

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_POINT = 1'b1
  } func_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } point_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } hz_t;

  function automatic word_t sat32(input logic signed [SUM_W-1:0] v);
    word_t r;
    if ((&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1])) begin
      r = v[WORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = WORD_MIN;
    end else begin
      r = WORD_MAX;
    end
    return r;
  endfunction

endpackage

// ----- sv/wsp_queue.sv -----
// ----------------------------------------------------------------------------
// wsp_queue
// two-entry point queue between front and back
// ----------------------------------------------------------------------------
module wsp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wsp_pkg::point_t   wdata,
  input  logic              pop,
  output wsp_pkg::point_t   rdata,
  output logic              full,
  output logic              empty
);

  wsp_pkg::point_t mem_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- sv/wsp_front.sv -----
// ----------------------------------------------------------------------------
// wsp_front
// request intake, matrix store and viewport registers
// ----------------------------------------------------------------------------
module wsp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic                         in_matrix_select,
  input  logic [3:0]                   in_element_index,
  input  logic signed [31:0]           in_element_value,
  input  logic signed [31:0]           in_world_x,
  input  logic signed [31:0]           in_world_y,
  input  logic signed [31:0]           in_world_z,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [wsp_pkg::DIM_W-1:0]    cfg_data,
  input  wsp_pkg::hz_t                 hz,
  input  logic                         q_full,
  input  logic                         q_empty,
  output logic                         q_push,
  output wsp_pkg::point_t              q_data,
  output wsp_pkg::mstore_t             mstore,
  output logic [wsp_pkg::DIM_W-1:0]    scr_w,
  output logic [wsp_pkg::DIM_W-1:0]    scr_h
);

  wsp_pkg::mstore_t              mstore_r;
  logic [wsp_pkg::DIM_W-1:0]     scr_w_r;
  logic [wsp_pkg::DIM_W-1:0]     scr_h_r;
  logic                          is_point;
  logic                          load_fire;
  logic [wsp_pkg::MAT_AW-1:0]    widx;

  assign is_point  = (in_func == wsp_pkg::FUNC_POINT);
  // loads wait until no queued or early-stage point still has to read a matrix
  assign in_ready  = is_point ? !q_full : (q_empty && !hz.a_valid && !hz.b_valid);
  assign q_push    = in_valid && in_ready && is_point;
  assign load_fire = in_valid && in_ready && !is_point;
  assign widx      = {in_matrix_select, in_element_index};
  assign q_data    = '{x: in_world_x, y: in_world_y, z: in_world_z};
  assign cfg_ready = 1'b1;
  assign mstore    = mstore_r;
  assign scr_w     = scr_w_r;
  assign scr_h     = scr_h_r;

  always_ff @(posedge clk) begin
    if (load_fire) begin
      mstore_r[widx] <= in_element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= wsp_pkg::WIDTH_RST;
      scr_h_r <= wsp_pkg::HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (wsp_pkg::reg_idx_t'(cfg_index))
        wsp_pkg::REG_WIDTH:  scr_w_r <= cfg_data;
        wsp_pkg::REG_HEIGHT: scr_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/wsp_div.sv -----
// ----------------------------------------------------------------------------
// wsp_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module wsp_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [wsp_pkg::DIV_W-1:0]     dvd,
  input  logic [wsp_pkg::WORD_W-1:0]    dvs,
  output logic [wsp_pkg::DIV_W-1:0]     quo
);

  localparam int N = wsp_pkg::DIV_W;
  localparam int W = wsp_pkg::WORD_W;

  logic [W-1:0] rem_r [N];
  logic [N-1:0] dq_r  [N];
  logic [W-1:0] dvs_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [W-1:0] rem_in;
    logic [W-1:0] dvs_in;
    logic [N-1:0] dq_in;
    logic [W:0]   sh;
    logic [W:0]   trial;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dvd;
      assign dvs_in = dvs;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign dq_in  = dq_r[i-1];
      assign dvs_in = dvs_r[i-1];
    end

    assign sh    = {rem_in, dq_in[N-1]};
    assign trial = sh - {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= trial[W] ? sh[W-1:0] : trial[W-1:0];
        dq_r[i]  <= {dq_in[N-2:0], !trial[W]};
        dvs_r[i] <= dvs_in;
      end
    end
  end

  assign quo = dq_r[N-1];

endmodule

// ----- sv/wsp_back.sv -----
// ----------------------------------------------------------------------------
// wsp_back
// transform, perspective divide, clip test and viewport mapping
// ----------------------------------------------------------------------------
module wsp_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  wsp_pkg::point_t                     q_data,
  output logic                                q_pop,
  input  wsp_pkg::mstore_t                    mstore,
  input  logic [wsp_pkg::DIM_W-1:0]           scr_w,
  input  logic [wsp_pkg::DIM_W-1:0]           scr_h,
  output wsp_pkg::hz_t                        hz,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_visible,
  output logic [wsp_pkg::PIX_W-1:0]           out_screen_x,
  output logic [wsp_pkg::PIX_W-1:0]           out_screen_y,
  output logic signed [wsp_pkg::WORD_W-1:0]   out_depth
);

  localparam int F  = wsp_pkg::FRAC_BITS;
  localparam int W  = wsp_pkg::WORD_W;
  localparam int PW = wsp_pkg::PROD_W;
  localparam int SW = wsp_pkg::SUM_W;
  localparam int N  = wsp_pkg::DIV_W;

  typedef struct packed {
    logic       wzero;
    logic [2:0] neg;
  } sb_t;

  function automatic wsp_pkg::word_t sat_q(input logic [N-1:0] q, input logic neg);
    wsp_pkg::word_t r;
    if (neg) begin
      if ((|q[N-1:W]) || (q[W-1] && (|q[W-2:0]))) begin
        r = wsp_pkg::WORD_MIN;
      end else begin
        r = -q[W-1:0];
      end
    end else begin
      if (|q[N-1:W-1]) begin
        r = wsp_pkg::WORD_MAX;
      end else begin
        r = q[W-1:0];
      end
    end
    return r;
  endfunction

  logic                   adv;
  wsp_pkg::word_t         vin [3];

  logic                   a_valid_r;
  logic signed [PW-1:0]   a_r   [4][4];
  logic signed [PW-1:0]   a_nxt [4][4];
  logic                   b_valid_r;
  wsp_pkg::word_t         b_r   [4];
  wsp_pkg::word_t         b_nxt [4];
  logic                   c_valid_r;
  logic signed [PW-1:0]   c_r   [4][4];
  logic signed [PW-1:0]   c_nxt [4][4];
  logic                   d_valid_r;
  wsp_pkg::word_t         d_r   [4];
  wsp_pkg::word_t         d_nxt [4];

  logic [N-1:0]           dvd   [3];
  logic [W-1:0]           dvs;
  logic [N-1:0]           quo   [3];
  sb_t                    sb_in;
  logic [N-1:0]           sv_r;
  sb_t                    sb_r  [N];

  logic                   f_valid_r;
  logic                   f_wzero_r;
  wsp_pkg::word_t         f_r   [3];
  wsp_pkg::word_t         f_nxt [3];

  logic                               vis;
  logic signed [wsp_pkg::FAR_W-1:0]   nz1000;
  logic signed [W:0]                  offx;
  logic signed [W:0]                  offy;
  logic [wsp_pkg::PM_W-1:0]           pmx;
  logic [wsp_pkg::PM_W-1:0]           pmy;
  logic [wsp_pkg::PXE_W-1:0]          pxx;
  logic [wsp_pkg::PXE_W-1:0]          pxy;
  logic [wsp_pkg::PIX_W-1:0]          sx;
  logic [wsp_pkg::PIX_W-1:0]          sy;

  logic                               out_valid_r;
  logic                               out_visible_r;
  logic [wsp_pkg::PIX_W-1:0]          out_sx_r;
  logic [wsp_pkg::PIX_W-1:0]          out_sy_r;
  wsp_pkg::word_t                     out_depth_r;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;
  assign hz    = '{a_valid: a_valid_r, b_valid: b_valid_r};

  assign vin[0] = q_data.x;
  assign vin[1] = q_data.y;
  assign vin[2] = q_data.z;

  // eye = [x y z 1] * model-view
  always_comb begin
    logic signed [2*W-1:0] p;
    p = '0;
    for (int j = 0; j < 4; j++) begin
      for (int c = 0; c < 3; c++) begin
        p = vin[c] * $signed(mstore[c*4+j]);
        a_nxt[j][c] = p[2*W-1:F];
      end
      a_nxt[j][3] = PW'($signed(mstore[12+j]));
    end
  end

  always_comb begin
    logic signed [SW-1:0] s;
    s = '0;
    for (int j = 0; j < 4; j++) begin
      s = SW'(a_r[j][0]) + SW'(a_r[j][1]) + SW'(a_r[j][2]) + SW'(a_r[j][3]);
      b_nxt[j] = wsp_pkg::sat32(s);
    end
  end

  // clip = eye * projection
  always_comb begin
    logic signed [2*W-1:0] p;
    p = '0;
    for (int j = 0; j < 4; j++) begin
      for (int c = 0; c < 4; c++) begin
        p = b_r[c] * $signed(mstore[16+c*4+j]);
        c_nxt[j][c] = p[2*W-1:F];
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] s;
    s = '0;
    for (int j = 0; j < 4; j++) begin
      s = SW'(c_r[j][0]) + SW'(c_r[j][1]) + SW'(c_r[j][2]) + SW'(c_r[j][3]);
      d_nxt[j] = wsp_pkg::sat32(s);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
    end
  end

  // sign-magnitude operands for the divide
  always_comb begin
    logic [W-1:0] mag;
    mag = '0;
    for (int k = 0; k < 3; k++) begin
      mag = d_r[k][W-1] ? W'(-d_r[k]) : W'(d_r[k]);
      dvd[k] = {mag, F'(0)};
      sb_in.neg[k] = d_r[k][W-1] ^ d_r[3][W-1];
    end
    dvs = d_r[3][W-1] ? W'(-d_r[3]) : W'(d_r[3]);
    sb_in.wzero = (d_r[3] == '0);
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    wsp_div u_div (
      .clk (clk),
      .en  (adv),
      .dvd (dvd[k]),
      .dvs (dvs),
      .quo (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= sb_in;
      for (int i = 1; i < N; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      f_nxt[k] = sat_q(quo[k], sb_r[N-1].neg[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r       <= f_nxt;
      f_wzero_r <= sb_r[N-1].wzero;
    end
  end

  // clip, far test and viewport mapping
  always_comb begin
    nz1000 = wsp_pkg::FAR_W'(f_r[2]) * wsp_pkg::FAR_W'(1000);
    vis = !f_wzero_r
       && (f_r[0] <= wsp_pkg::FX_ONE) && (f_r[0] >= -wsp_pkg::FX_ONE)
       && (f_r[1] <= wsp_pkg::FX_ONE) && (f_r[1] >= -wsp_pkg::FX_ONE)
       && (nz1000 < wsp_pkg::FAR_LIM);
    offx = (W+1)'(f_r[0]) + (W+1)'(wsp_pkg::FX_ONE);
    offy = (W+1)'(wsp_pkg::FX_ONE) - (W+1)'(f_r[1]);
    pmx  = wsp_pkg::PM_W'(offx[wsp_pkg::OFF_W-1:0]) * wsp_pkg::PM_W'(scr_w);
    pmy  = wsp_pkg::PM_W'(offy[wsp_pkg::OFF_W-1:0]) * wsp_pkg::PM_W'(scr_h);
    pxx  = wsp_pkg::PXE_W'(pmx) >> 1;
    pxy  = wsp_pkg::PXE_W'(pmy) >> 1;
    sx   = (|pxx[wsp_pkg::PXE_W-1:wsp_pkg::PIX_W]) ? '1 : pxx[wsp_pkg::PIX_W-1:0];
    sy   = (|pxy[wsp_pkg::PXE_W-1:wsp_pkg::PIX_W]) ? '1 : pxy[wsp_pkg::PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_visible_r <= vis;
      out_sx_r      <= vis ? sx : '0;
      out_sy_r      <= vis ? sy : '0;
      out_depth_r   <= vis ? f_r[2] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      sv_r        <= '0;
      f_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= q_pop;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      sv_r        <= {sv_r[N-2:0], d_valid_r};
      f_valid_r   <= sv_r[N-1];
      out_valid_r <= f_valid_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_visible  = out_visible_r;
  assign out_screen_x = out_sx_r;
  assign out_screen_y = out_sy_r;
  assign out_depth    = out_depth_r;

endmodule

// ----- sv/world_to_screen_projection_top.sv -----
// ----------------------------------------------------------------------------
// world_to_screen_projection_top
// fixed-point vertex projection: model-view, projection, divide, viewport
// ----------------------------------------------------------------------------
// Takes one point request per cycle while the input queue has room, and
// returns one result per point. Matrix load requests produce no result. The
// bit-per-stage perspective divider has 32 + FRAC_BITS stages for Q16.16
// values. A load is held off while a point sits in the input queue or in the
// first two transform stages, so a load right behind a point waits until the
// point has left them, and longer while the output stalls. Viewport registers
// are written through the cfg port with the unit idle; the user must keep to
// this, the block itself does not enforce it. The whole back end advances
// whenever the output register is empty or taken.
module world_to_screen_projection_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic                                in_matrix_select,
  input  logic [3:0]                          in_element_index,
  input  logic signed [31:0]                  in_element_value,
  input  logic signed [31:0]                  in_world_x,
  input  logic signed [31:0]                  in_world_y,
  input  logic signed [31:0]                  in_world_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_visible,
  output logic [wsp_pkg::PIX_W-1:0]           out_screen_x,
  output logic [wsp_pkg::PIX_W-1:0]           out_screen_y,
  output logic signed [wsp_pkg::WORD_W-1:0]   out_depth,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [wsp_pkg::DIM_W-1:0]           cfg_data
);

  wsp_pkg::hz_t                 hz;
  logic                         q_full;
  logic                         q_empty;
  logic                         q_push;
  logic                         q_pop;
  wsp_pkg::point_t              q_wdata;
  wsp_pkg::point_t              q_rdata;
  wsp_pkg::mstore_t             mstore;
  logic [wsp_pkg::DIM_W-1:0]    scr_w;
  logic [wsp_pkg::DIM_W-1:0]    scr_h;
  logic                         load_acc;
  logic                         out_zero;

  wsp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_matrix_select (in_matrix_select),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .in_world_x       (in_world_x),
    .in_world_y       (in_world_y),
    .in_world_z       (in_world_z),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .hz               (hz),
    .q_full           (q_full),
    .q_empty          (q_empty),
    .q_push           (q_push),
    .q_data           (q_wdata),
    .mstore           (mstore),
    .scr_w            (scr_w),
    .scr_h            (scr_h)
  );

  wsp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  wsp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .mstore       (mstore),
    .scr_w        (scr_w),
    .scr_h        (scr_h),
    .hz           (hz),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_visible  (out_visible),
    .out_screen_x (out_screen_x),
    .out_screen_y (out_screen_y),
    .out_depth    (out_depth)
  );

  assign load_acc = in_valid && in_ready && (in_func == wsp_pkg::FUNC_LOAD);
  assign out_zero = (out_screen_x == '0) && (out_screen_y == '0) && (out_depth == '0);

`include "world_to_screen_projection_top_assert.svh"

  `WSP_ASSERT_IMP(a_load_no_pending, load_acc, q_empty && !hz.a_valid && !hz.b_valid)
  `WSP_ASSERT_IMP(a_hidden_zero, out_valid && !out_visible, out_zero)
  `WSP_ASSERT_IMP(a_no_push_full, q_push, !q_full)
  `WSP_ASSERT_NXT(a_push_fills, q_push && !q_pop, !q_empty)

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// vertex projection unit testbench: matrix loads and point requests are driven
// with random gaps, results are checked against a cycle-free projector model
// held in a small scoreboard class, across several viewport settings
// ----------------------------------------------------------------------------
module tb;
  import wsp_pkg::*;

  localparam int DRAIN_CYCLES = 70;
  localparam int STALL_LIMIT  = 3000;
  localparam longint ONE      = longint'(1) << FRAC_BITS;
  localparam longint PIX_MAX  = (longint'(1) << PIX_W) - 1;

  typedef struct {
    func_t       func;
    logic        sel;
    logic [3:0]  idx;
    word_t       val;
    word_t       x;
    word_t       y;
    word_t       z;
  } request_t;

  typedef struct {
    logic              visible;
    logic [PIX_W-1:0]  sx;
    logic [PIX_W-1:0]  sy;
    word_t             depth;
  } pixel_t;

  class vertex_projector;
    word_t   mat[32];
    longint  width;
    longint  height;
    pixel_t  expected_pixels[$];
    int      errors;

    function new();
      width  = WIDTH_RST;
      height = HEIGHT_RST;
      errors = 0;
      foreach (mat[i]) mat[i] = '0;
    endfunction

    function void set_viewport(reg_idx_t r, logic [DIM_W-1:0] d);
      if (r == REG_WIDTH) width = d;
      else height = d;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void transform(longint v[4], int base, output longint r[4]);
      longint acc;
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int c = 0; c < 4; c++)
          acc += (v[c] * longint'(mat[base + c * 4 + j])) >>> FRAC_BITS;
        r[j] = clamp32(acc);
      end
    endfunction

    function longint to_pixel(longint off, longint size);
      longint p;
      p = (off * size) >>> 1;
      return (p > PIX_MAX) ? PIX_MAX : p;
    endfunction

    function void note_request(request_t q);
      longint v[4], eye[4], clip[4];
      longint nx, ny, nz, w;
      pixel_t e;
      if (q.func == FUNC_LOAD) begin
        mat[{q.sel, q.idx}] = q.val;
        return;
      end
      e = '{1'b0, '0, '0, '0};
      v[0] = q.x; v[1] = q.y; v[2] = q.z; v[3] = ONE;
      transform(v, 0, eye);
      transform(eye, 16, clip);
      w = clip[3];
      if (w != 0) begin
        nx = clamp32((clip[0] * ONE) / w);
        ny = clamp32((clip[1] * ONE) / w);
        nz = clamp32((clip[2] * ONE) / w);
        if (nx <= ONE && nx >= -ONE && ny <= ONE && ny >= -ONE &&
            nz * 1000 < 999 * ONE) begin
          e.visible = 1'b1;
          e.sx      = PIX_W'(to_pixel(nx + ONE, width));
          e.sy      = PIX_W'(to_pixel(ONE - ny, height));
          e.depth   = word_t'(nz);
        end
      end
      expected_pixels.push_back(e);
    endfunction

    function void check_pixel(pixel_t a);
      pixel_t e;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result vis=%0d sx=%h sy=%h depth=%h",
                 $time, a.visible, a.sx, a.sy, a.depth);
        errors++;
        return;
      end
      e = expected_pixels.pop_front();
      if (a.visible !== e.visible) begin
        $display("%0t: visible exp %0d got %0d", $time, e.visible, a.visible);
        errors++;
      end
      if (a.sx !== e.sx) begin
        $display("%0t: screen_x exp %h got %h", $time, e.sx, a.sx);
        errors++;
      end
      if (a.sy !== e.sy) begin
        $display("%0t: screen_y exp %h got %h", $time, e.sy, a.sy);
        errors++;
      end
      if (a.depth !== e.depth) begin
        $display("%0t: depth exp %h got %h", $time, e.depth, a.depth);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic in_matrix_select = 1'b0;
  logic [3:0] in_element_index = '0;
  logic signed [31:0] in_element_value = '0;
  logic signed [31:0] in_world_x = '0;
  logic signed [31:0] in_world_y = '0;
  logic signed [31:0] in_world_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_visible;
  logic [PIX_W-1:0] out_screen_x;
  logic [PIX_W-1:0] out_screen_y;
  logic signed [WORD_W-1:0] out_depth;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [DIM_W-1:0] cfg_data = '0;

  vertex_projector proj = new();
  bit calm = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  world_to_screen_projection_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side with random backpressure
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      proj.check_pixel('{out_visible, out_screen_x, out_screen_y, out_depth});
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout at %0t", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_request(request_t q);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= q.func;
    in_matrix_select <= q.sel;
    in_element_index <= q.idx;
    in_element_value <= q.val;
    in_world_x       <= q.x;
    in_world_y       <= q.y;
    in_world_z       <= q.z;
    do @(posedge clk); while (!in_ready);
    proj.note_request(q);
  endtask

  task automatic load(logic sel, int idx, longint v);
    request_t q;
    q = '{FUNC_LOAD, sel, 4'(idx), word_t'(v), word_t'($urandom), word_t'($urandom),
          word_t'($urandom)};
    send_request(q);
  endtask

  task automatic point(longint x, longint y, longint z);
    request_t q;
    q = '{FUNC_POINT, 1'($urandom), 4'($urandom), word_t'($urandom), word_t'(x),
          word_t'(y), word_t'(z)};
    send_request(q);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (proj.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_viewport(reg_idx_t r, logic [DIM_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    proj.set_viewport(r, d);
  endtask

  function automatic longint rnd(longint lo, longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  // well-behaved model-view and perspective projection (partly random when wild is set), loaded in random order
  task automatic load_camera(bit wild);
    longint m[32];
    int ord[32];
    foreach (m[i]) m[i] = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r * 4 + c] = (r == c) ? rnd(ONE / 2, 2 * ONE) : rnd(-ONE / 4, ONE / 4);
    for (int c = 0; c < 3; c++) m[12 + c] = rnd(-2 * ONE, 2 * ONE);
    m[15] = ONE;
    m[16] = rnd(ONE / 2, 3 * ONE);
    m[16 + 5] = rnd(ONE / 2, 3 * ONE);
    m[16 + 10] = -66847 + rnd(-2000, 2000);
    m[16 + 11] = -ONE;
    m[16 + 14] = -132383 + rnd(-5000, 5000);
    if (wild) foreach (m[i]) if ($urandom_range(0, 3) == 0) m[i] = longint'(int'($urandom));
    foreach (ord[i]) ord[i] = i;
    ord.shuffle();
    foreach (ord[i]) load(ord[i][4], ord[i] % 16, m[ord[i]]);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: point(longint'(int'($urandom)), longint'(int'($urandom)),
                 longint'(int'($urandom)));
        1: load(1'($urandom), $urandom_range(0, 15), longint'(int'($urandom)));
        2: load(1'($urandom), $urandom_range(0, 15), rnd(-ONE, ONE));
        default: point(rnd(-8 * ONE, 8 * ONE), rnd(-8 * ONE, 8 * ONE),
                       rnd(-60 * ONE, 2 * ONE));
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity model-view, unit perspective
    for (int i = 0; i < 32; i++)
      load(i[4], i % 16, (i == 0 || i == 5 || i == 10 || i == 15 || i == 16 || i == 21) ?
           ONE : (i == 26) ? -66847 : (i == 27) ? -ONE : (i == 30) ? -132383 : 0);
    point(0, 0, -5 * ONE);
    point(5 * ONE, 5 * ONE, -5 * ONE);
    point(-5 * ONE, -5 * ONE, -5 * ONE);
    point(5 * ONE + 1, 0, -5 * ONE);
    point(0, 0, 0);
    point(ONE, ONE, ONE);
    point(0, 0, -1000 * ONE);
    point(0, 0, -2 * ONE);
    point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    point(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
    point(32'sh7FFFFFFF, -64'sd2147483648, -ONE);
    point(1, -1, -ONE);
    point(-ONE, ONE, -ONE);
    random_phase(30);

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: begin write_viewport(REG_WIDTH, 1); write_viewport(REG_HEIGHT, 1); end
        1: begin write_viewport(REG_WIDTH, 16383); write_viewport(REG_HEIGHT, 16383); end
        2: begin write_viewport(REG_WIDTH, 0); write_viewport(REG_HEIGHT, 0); end
        default: begin
          write_viewport(REG_WIDTH, DIM_W'($urandom));
          write_viewport(REG_HEIGHT, DIM_W'($urandom));
        end
      endcase
      load_camera(ph == 4);
      if (ph == 6) calm = 1'b1;
      random_phase(75);
    end

    drain();
    if (proj.errors == 0 && proj.expected_pixels.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
